/* design/sll_pkg.sv */
// Shared types, constants and helpers for the static linked list engine.
// Used by static_linked_list_engine; no dependencies of its own.
`default_nettype none

package sll_pkg;

   // Store geometry; slot fields are fixed at five bits
   localparam int STORE_DEPTH = 32;
   localparam int SLOT_W      = $clog2(STORE_DEPTH);
   localparam int DATA_W      = 8;
   localparam int MAX_RESULTS = 30;

   localparam logic [SLOT_W-1:0] FREE_HEAD = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(1);
   localparam logic [DATA_W-1:0] BLANK     = DATA_W'(32);

   // Command codes
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_FIND   = 3'd3;
   localparam logic [2:0] CMD_AMEND  = 3'd4;
   localparam logic [2:0] CMD_LIST   = 3'd5;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_BAD_POS   = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]        command;
      logic [4:0]        position;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
      logic              last;
   } rsp_type;

   // Link value of a slot that has not been written since init
   function automatic logic [SLOT_W-1:0] rst_next(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == FREE_HEAD) begin
         r = HEAD_SLOT + SLOT_W'(1);
      end else if (s == HEAD_SLOT) begin
         r = SLOT_W'(0);
      end else if (int'(s) == STORE_DEPTH - 1) begin
         r = SLOT_W'(0);
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

   // A link that points at a real node (zero ends a chain)
   function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
      return (s != SLOT_W'(0)) && (int'(s) < STORE_DEPTH);
   endfunction

endpackage

`default_nettype wire

/* design/static_linked_list_engine.sv */
// Static linked list engine: node store with a data list and a free list.
// Depends on sll_pkg and sll_ram.
`default_nettype none

//  channel  direction  handshake              payload
//  req_     in         req_valid / req_stall  sll_pkg::req_type
//  rsp_     out        rsp_valid / rsp_stall  sll_pkg::rsp_type
//
// One request at a time; search walks the chain one node per cycle through the single
// read port of the link and data RAMs, and list does so while the response is not
// stalled; insert visits each node in a read state and then a check state. Insert
// position 0 is treated as position 1. Reset (synchronous) and init clear per-entry
// valid bits, so no clearing pass is needed. A stalled response holds; the next
// request is taken while it waits.

module static_linked_list_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire sll_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      sll_pkg::rsp_type rsp_data
);

   typedef enum logic [13:0] {
      S_IDLE       = 14'b00000000000001,
      S_INS_RD     = 14'b00000000000010,
      S_INS_CHK    = 14'b00000000000100,
      S_INS_FREE   = 14'b00000000001000,
      S_INS_A      = 14'b00000000010000,
      S_INS_B      = 14'b00000000100000,
      S_INS_C      = 14'b00000001000000,
      S_SRCH_FIRST = 14'b00000010000000,
      S_SRCH_CHK   = 14'b00000100000000,
      S_DEL_A      = 14'b00001000000000,
      S_DEL_B      = 14'b00010000000000,
      S_LST_FIRST  = 14'b00100000000000,
      S_LST_CHK    = 14'b01000000000000,
      S_EMIT       = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // Walk registers
   logic [sll_pkg::SLOT_W-1:0] cur_ff, cur_in;
   logic [sll_pkg::SLOT_W-1:0] prev_ff, prev_in;
   logic [sll_pkg::SLOT_W-1:0] hit_ff, hit_in;
   logic [sll_pkg::SLOT_W-1:0] steps_ff, steps_in;
   sll_pkg::req_type           req_ff, req_in;
   sll_pkg::rsp_type           res_ff, res_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   sll_pkg::rsp_type rsp_ff, rsp_in;
   logic             out_free;
   logic             load;
   sll_pkg::rsp_type load_data;

   // Memory ports
   logic [sll_pkg::SLOT_W-1:0] rd_addr;
   logic                       wn_en, wd_en;
   logic [sll_pkg::SLOT_W-1:0] wn_addr, wd_addr;
   logic [sll_pkg::SLOT_W-1:0] wn_data;
   logic [sll_pkg::DATA_W-1:0] wd_data;
   logic [sll_pkg::SLOT_W-1:0] ram_next;
   logic [sll_pkg::DATA_W-1:0] ram_data;
   logic                       clr_vld;

   // Per-entry written flags and the read-side capture
   logic [sll_pkg::STORE_DEPTH-1:0] vn_vld_ff, vd_vld_ff;
   logic [sll_pkg::SLOT_W-1:0]      rd_addr_q_ff;
   logic                            vn_q_ff, vd_q_ff;
   logic [sll_pkg::SLOT_W-1:0]      mem_next;
   logic [sll_pkg::DATA_W-1:0]      mem_data;

   sll_ram #(.WIDTH(sll_pkg::SLOT_W), .DEPTH(sll_pkg::STORE_DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (wn_en),
      .wr_addr (wn_addr),
      .wr_data (wn_data),
      .rd_addr (rd_addr),
      .rd_data (ram_next)
   );

   sll_ram #(.WIDTH(sll_pkg::DATA_W), .DEPTH(sll_pkg::STORE_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (wd_en),
      .wr_addr (wd_addr),
      .wr_data (wd_data),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   // Unwritten entries read as their init values
   assign mem_next = vn_q_ff ? ram_next : sll_pkg::rst_next(rd_addr_q_ff);
   assign mem_data = vd_q_ff ? ram_data : sll_pkg::BLANK;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      hit_in    = hit_ff;
      steps_in  = steps_ff;
      req_in    = req_ff;
      res_in    = res_ff;
      rd_addr   = cur_ff;
      wn_en     = 1'b0;
      wn_addr   = cur_ff;
      wn_data   = mem_next;
      wd_en     = 1'b0;
      wd_addr   = cur_ff;
      wd_data   = req_ff.value;
      clr_vld   = 1'b0;
      load      = 1'b0;
      load_data = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               case (req_data.command)
                  sll_pkg::CMD_INIT: begin
                     clr_vld  = 1'b1;
                     res_in   = '{sll_pkg::ST_OK, sll_pkg::HEAD_SLOT, '0, 1'b1};
                     state_in = S_EMIT;
                  end
                  sll_pkg::CMD_INSERT: begin
                     cur_in   = sll_pkg::HEAD_SLOT;
                     steps_in = (req_data.position == 5'd0) ? '0
                                                            : req_data.position - 5'd1;
                     state_in = S_INS_RD;
                  end
                  sll_pkg::CMD_DELETE, sll_pkg::CMD_FIND, sll_pkg::CMD_AMEND: begin
                     rd_addr  = sll_pkg::HEAD_SLOT;
                     prev_in  = sll_pkg::HEAD_SLOT;
                     steps_in = '0;
                     state_in = S_SRCH_FIRST;
                  end
                  sll_pkg::CMD_LIST: begin
                     rd_addr  = sll_pkg::HEAD_SLOT;
                     steps_in = '0;
                     state_in = S_LST_FIRST;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Walk to the node after which the new one goes
         S_INS_RD: begin
            if (steps_ff == '0) begin
               rd_addr  = sll_pkg::FREE_HEAD;
               state_in = S_INS_FREE;
            end else begin
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (!sll_pkg::slot_ok(mem_next)) begin
               res_in   = '{sll_pkg::ST_BAD_POS, '0, '0, 1'b1};
               state_in = S_EMIT;
            end else begin
               cur_in   = mem_next;
               steps_in = steps_ff - 5'd1;
               state_in = S_INS_RD;
            end
         end
         // Take a node off the free list and splice it in
         S_INS_FREE: begin
            if (!sll_pkg::slot_ok(mem_next)) begin
               res_in   = '{sll_pkg::ST_FULL, '0, '0, 1'b1};
               state_in = S_EMIT;
            end else begin
               hit_in   = mem_next;
               rd_addr  = mem_next;
               state_in = S_INS_A;
            end
         end
         S_INS_A: begin
            wn_en    = 1'b1;
            wn_addr  = sll_pkg::FREE_HEAD;
            wn_data  = mem_next;
            rd_addr  = cur_ff;
            state_in = S_INS_B;
         end
         S_INS_B: begin
            wn_en    = 1'b1;
            wn_addr  = hit_ff;
            wn_data  = mem_next;
            wd_en    = 1'b1;
            wd_addr  = hit_ff;
            wd_data  = req_ff.value;
            state_in = S_INS_C;
         end
         S_INS_C: begin
            wn_en    = 1'b1;
            wn_addr  = cur_ff;
            wn_data  = hit_ff;
            res_in   = '{sll_pkg::ST_OK, hit_ff, '0, 1'b1};
            state_in = S_EMIT;
         end

         // Search the data list, header excluded
         S_SRCH_FIRST: begin
            if (!sll_pkg::slot_ok(mem_next)) begin
               res_in   = '{sll_pkg::ST_NOT_FOUND, '0, '0, 1'b1};
               state_in = S_EMIT;
            end else begin
               cur_in   = mem_next;
               rd_addr  = mem_next;
               state_in = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (mem_data == req_ff.value) begin
               hit_in = cur_ff;
               res_in = '{sll_pkg::ST_OK, cur_ff, '0, 1'b1};
               case (req_ff.command)
                  sll_pkg::CMD_DELETE: begin
                     // unlink now, then push onto the free list
                     wn_en    = 1'b1;
                     wn_addr  = prev_ff;
                     wn_data  = mem_next;
                     rd_addr  = sll_pkg::FREE_HEAD;
                     state_in = S_DEL_A;
                  end
                  sll_pkg::CMD_AMEND: begin
                     wd_en    = 1'b1;
                     wd_addr  = cur_ff;
                     wd_data  = req_ff.new_value;
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end else if (steps_ff == sll_pkg::SLOT_W'(sll_pkg::STORE_DEPTH - 1) ||
                         !sll_pkg::slot_ok(mem_next)) begin
               res_in   = '{sll_pkg::ST_NOT_FOUND, '0, '0, 1'b1};
               state_in = S_EMIT;
            end else begin
               prev_in  = cur_ff;
               cur_in   = mem_next;
               rd_addr  = mem_next;
               steps_in = steps_ff + 5'd1;
            end
         end
         S_DEL_A: begin
            wn_en    = 1'b1;
            wn_addr  = hit_ff;
            wn_data  = mem_next;
            state_in = S_DEL_B;
         end
         S_DEL_B: begin
            wn_en    = 1'b1;
            wn_addr  = sll_pkg::FREE_HEAD;
            wn_data  = hit_ff;
            state_in = S_EMIT;
         end

         // List: one response per element, straight into the output register
         S_LST_FIRST: begin
            if (!sll_pkg::slot_ok(mem_next)) begin
               res_in   = '{sll_pkg::ST_EMPTY, '0, '0, 1'b1};
               state_in = S_EMIT;
            end else begin
               cur_in   = mem_next;
               rd_addr  = mem_next;
               state_in = S_LST_CHK;
            end
         end
         S_LST_CHK: begin
            if (out_free) begin
               load = 1'b1;
               load_data.status = sll_pkg::ST_OK;
               load_data.slot   = cur_ff;
               load_data.data   = mem_data;
               load_data.last   = !sll_pkg::slot_ok(mem_next) ||
                  (steps_ff == sll_pkg::SLOT_W'(sll_pkg::MAX_RESULTS - 1));
               if (load_data.last) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in   = mem_next;
                  rd_addr  = mem_next;
                  steps_in = steps_ff + 5'd1;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = load_data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vn_vld_ff    <= '0;
         vd_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr_vld) begin
            vn_vld_ff <= '0;
            vd_vld_ff <= '0;
         end else begin
            if (wn_en) begin
               vn_vld_ff[wn_addr] <= 1'b1;
            end
            if (wd_en) begin
               vd_vld_ff[wd_addr] <= 1'b1;
            end
         end
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      hit_ff       <= hit_in;
      steps_ff     <= steps_in;
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      rd_addr_q_ff <= rd_addr;
      vn_q_ff      <= vn_vld_ff[rd_addr];
      vd_q_ff      <= vd_vld_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* design/sll_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
